// ===== rtl/rtte_pkg.sv =====
// ----------------------------------------------------------------------------
// rtte_pkg
// Shared types, constants and the clamp function of the RTT estimator and
// retransmit timer.
// ----------------------------------------------------------------------------
package rtte_pkg;

  // Field widths
  localparam int unsigned MS_W    = 16;  // millisecond values
  localparam int unsigned CNT_W   = 8;   // retransmit count
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_A_W = 2;   // register index
  localparam int unsigned CFG_D_W = 16;  // register write data
  localparam int unsigned SUM_W   = MS_W + 3;  // srtt + 4*rttvar, no wrap

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_NEW_PKT = 2'd1,
    CMD_SAMPLE  = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  // Register indexes
  localparam logic [CFG_A_W-1:0] REG_MIN_RTO   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_MAX_RTO   = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_RETX  = 2'd2;

  // Reset and init values
  localparam logic [MS_W-1:0]  RST_MIN_RTO   = 16'd2000;
  localparam logic [MS_W-1:0]  RST_MAX_RTO   = 16'd60000;
  localparam logic [CNT_W-1:0] RST_MAX_RETX  = 8'd3;
  localparam logic [MS_W-1:0]  INIT_DEV      = 16'd750;
  localparam logic [SUM_W-1:0] INIT_RTO_RAW  = {1'b0, INIT_DEV, 2'b00};  // 0 + 4*750
  localparam logic [MS_W-1:0]  RST_RTO       = 16'd3000;  // 3000 within reset clamps
  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

  // Estimator state
  typedef struct packed {
    logic [MS_W-1:0]  srtt;
    logic [MS_W-1:0]  rttvar;
    logic [MS_W-1:0]  rto;
    logic [CNT_W-1:0] retry;
  } est_state_t;

  // Configuration registers
  typedef struct packed {
    logic [MS_W-1:0]  min_rto;
    logic [MS_W-1:0]  max_rto;
    logic [CNT_W-1:0] max_retx;
  } rto_cfg_t;

  // When the clamps cross, a value below min_rto gets min_rto and any other value gets max_rto
  function automatic logic [MS_W-1:0] clamp_rto(logic [SUM_W-1:0] v, rto_cfg_t cfg);
    logic [MS_W-1:0] res;
    if (v < {3'b000, cfg.min_rto}) begin
      res = cfg.min_rto;
    end else if (v > {3'b000, cfg.max_rto}) begin
      res = cfg.max_rto;
    end else begin
      res = v[MS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/rtte_update.sv =====
// ----------------------------------------------------------------------------
// rtte_update
// Next-state logic for one command: estimator update, timeout backoff,
// clamp and retransmit counting.
// ----------------------------------------------------------------------------
module rtte_update (
  input  rtte_pkg::cmd_t               cmd_i,
  input  logic [rtte_pkg::MS_W-1:0]    sample_i,
  input  rtte_pkg::est_state_t         st_i,
  input  rtte_pkg::rto_cfg_t           cfg_i,
  output rtte_pkg::est_state_t         st_o,
  output logic                         give_up_o
);
  import rtte_pkg::*;

  logic signed [MS_W:0] delta;
  logic signed [MS_W:0] delta_q;     // delta / 8 toward zero
  logic        [MS_W:0] delta_neg;
  logic [MS_W-1:0]      mag;
  logic signed [MS_W:0] dev_diff;
  logic signed [MS_W:0] dev_q;       // (mag - rttvar) / 4 toward zero
  logic [MS_W-1:0]      srtt_new;
  logic [MS_W-1:0]      rttvar_new;
  logic [SUM_W-1:0]     rto_sum;
  logic [CNT_W-1:0]     retry_inc;

  // Sample path: signed error, truncating divides, new timeout candidate
  always_comb begin
    delta     = $signed({1'b0, sample_i}) - $signed({1'b0, st_i.srtt});
    delta_q   = (delta + $signed({{(MS_W-2){1'b0}}, {3{delta[MS_W]}}})) >>> 3;
    delta_neg = -delta;
    mag       = delta[MS_W] ? delta_neg[MS_W-1:0] : delta[MS_W-1:0];
    dev_diff  = $signed({1'b0, mag}) - $signed({1'b0, st_i.rttvar});
    dev_q     = (dev_diff + $signed({{(MS_W-1){1'b0}}, {2{dev_diff[MS_W]}}})) >>> 2;
    // results stay in 16 bits, so modular adds are exact
    srtt_new   = st_i.srtt + delta_q[MS_W-1:0];
    rttvar_new = st_i.rttvar + dev_q[MS_W-1:0];
    rto_sum    = {3'b000, srtt_new} + {1'b0, rttvar_new, 2'b00};
  end

  // Saturating retry count for a timeout
  assign retry_inc = (st_i.retry == CNT_MAX) ? st_i.retry : st_i.retry + 1'b1;

  // Command decode
  always_comb begin
    st_o      = st_i;
    give_up_o = 1'b0;
    unique case (cmd_i)
      CMD_INIT: begin
        st_o.srtt   = '0;
        st_o.rttvar = INIT_DEV;
        st_o.rto    = clamp_rto(INIT_RTO_RAW, cfg_i);
      end
      CMD_NEW_PKT: begin
        st_o.retry = '0;
      end
      CMD_SAMPLE: begin
        st_o.srtt   = srtt_new;
        st_o.rttvar = rttvar_new;
        st_o.rto    = clamp_rto(rto_sum, cfg_i);
      end
      CMD_TIMEOUT: begin
        st_o.rto   = clamp_rto({2'b00, st_i.rto, 1'b0}, cfg_i);
        st_o.retry = retry_inc;
        give_up_o  = (retry_inc > cfg_i.max_retx);
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

// ===== rtl/rtt_estimator_retransmit_timer_unit.sv =====
// ----------------------------------------------------------------------------
// rtt_estimator_retransmit_timer_unit
// Retransmission-timeout estimator: smoothed RTT and mean deviation in
// integer ms, clamped timeout with doubling backoff, retransmit counting.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  in_       request    valid / stall    command, rtt_sample_ms
//  out_      result     valid / stall    current_rto, give_up, retransmit_count
//  cfg_      write      valid / ready    index, wdata (min_rto, max_rto, max_retx)
//
//  One request per cycle while out_stall is low; a request passes the request
//  register, then the result register, with the state update between the two.
//  A stalled result holds; the request register keeps filling behind it and
//  in_stall rises only when both stages are full.
//  Synchronous active-low reset restores valid flags, config and estimator state.
//  Config writes are always ready; they do not recompute the current timeout.
// ----------------------------------------------------------------------------
module rtt_estimator_retransmit_timer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rtte_pkg::CMD_W-1:0]      in_command,
  input  logic [rtte_pkg::MS_W-1:0]       in_rtt_sample_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rtte_pkg::MS_W-1:0]       out_current_rto,
  output logic                            out_give_up,
  output logic [rtte_pkg::CNT_W-1:0]      out_retransmit_count,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtte_pkg::CFG_A_W-1:0]    cfg_index,
  input  logic [rtte_pkg::CFG_D_W-1:0]    cfg_wdata
);
  import rtte_pkg::*;

  logic              in_valid_r;
  cmd_t              in_cmd_r;
  logic [MS_W-1:0]   in_sample_r;
  est_state_t        st_r;
  est_state_t        st_nxt;
  logic              give_up_nxt;
  rto_cfg_t          cfg_r;
  logic              out_valid_r;
  logic [MS_W-1:0]   out_rto_r;
  logic              out_give_up_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              advance;

  // Result stage free to take the request stage
  assign advance   = ~out_valid_r | ~out_stall;
  assign in_stall  = in_valid_r & ~advance;
  assign cfg_ready = 1'b1;

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_cmd_r    <= cmd_t'(in_command);
      in_sample_r <= in_rtt_sample_ms;
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_rto  <= RST_MIN_RTO;
      cfg_r.max_rto  <= RST_MAX_RTO;
      cfg_r.max_retx <= RST_MAX_RETX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_RTO:  cfg_r.min_rto  <= cfg_wdata[MS_W-1:0];
        REG_MAX_RTO:  cfg_r.max_rto  <= cfg_wdata[MS_W-1:0];
        REG_MAX_RETX: cfg_r.max_retx <= cfg_wdata[CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  rtte_update u_update (
    .cmd_i     (in_cmd_r),
    .sample_i  (in_sample_r),
    .st_i      (st_r),
    .cfg_i     (cfg_r),
    .st_o      (st_nxt),
    .give_up_o (give_up_nxt)
  );

  // Estimator state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.srtt   <= '0;
      st_r.rttvar <= INIT_DEV;
      st_r.rto    <= RST_RTO;
      st_r.retry  <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
    if (advance && in_valid_r) begin
      out_rto_r     <= st_nxt.rto;
      out_give_up_r <= give_up_nxt;
      out_cnt_r     <= st_nxt.retry;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_current_rto      = out_rto_r;
  assign out_give_up          = out_give_up_r;
  assign out_retransmit_count = out_cnt_r;

endmodule

// ===== rtl/rtte_checker.sv =====
// ----------------------------------------------------------------------------
// rtte_checker
// Port-level checks of the RTT estimator: result hold under stall, give-up
// consistency and a request reaching an empty result stage through both registers.
// ----------------------------------------------------------------------------
module rtte_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rtte_pkg::MS_W-1:0]     out_current_rto,
  input logic                          out_give_up,
  input logic [rtte_pkg::CNT_W-1:0]    out_retransmit_count
);

  // Stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result payload holds
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_current_rto) && $stable(out_give_up)
                               && $stable(out_retransmit_count))
    else $error("result payload changed while stalled");

  // Give-up only after at least one retransmission
  a_give_up_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_give_up |-> out_retransmit_count != '0)
    else $error("give_up with zero retransmit count");

  // Request into an empty result stage shows up after the request and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("result missing two cycles after request");

endmodule

bind rtt_estimator_retransmit_timer_unit rtte_checker u_rtte_checker (.*);
